>>> hw/rtl/dwpli_pkg.sv
// Shared types and constants of the debiased wPLI accumulator.
package dwpli_pkg;

  localparam int SLOT_W = 12;
  localparam int X_W    = 24;
  localparam int SUM_W  = 34;
  localparam int ABS_W  = 34;
  localparam int SQ_W   = 56;
  localparam int PLI_W  = 18;
  localparam int CMD_W  = 2;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + MUL_B_W;
  // doubled divide remainder needs one bit above ACC_W, plus the sign
  localparam int WIDE_W  = ACC_W + 2;
  localparam int DIV_STEPS = 16;
  localparam int QUO_W   = DIV_STEPS + 1;

  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic signed [SUM_W:0] SUM_MAX = 35'sh1_FFFF_FFFF;
  localparam logic signed [SUM_W:0] SUM_MIN = -35'sh2_0000_0000;
  localparam logic [QUO_W-1:0] ONE_Q16 = 17'h1_0000;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [ABS_W-1:0]        abs_sum;
    logic [SQ_W-1:0]         sq_sum;
  } sums_t;

endpackage

>>> hw/rtl/debiased_wpli_accumulator_top.sv
// Debiased squared wPLI accumulator: per-slot sums in one memory, shared mul/sub sequencer.
// Clear: the entry is zeroed as the command is accepted. Accumulate: accept, read, 3 multiply steps, write.
// Read: accept, read, 5 multiply steps on a 34x17 multiplier, compare steps (DEN, MAG, CMP) on the
// shared 70-bit subtractor that can skip the 16 divide steps, then output; a waiting result stalls it.
// rst is synchronous; then a clearing pass zeroes one memory entry per cycle over all DEPTH entries
// (SLOTS, at most 4096) and s_axis_tready stays low until it ends.
module debiased_wpli_accumulator_top #(
  parameter int SLOTS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [11:0] slot, [35:12] csd_imag, [39:36] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [11:0] slot_out, [29:12] phase_lag_index, [31:30] zero
  output logic        m_axis_tuser   // [0] zero_denominator
);

  localparam int DEPTH = (SLOTS > 4096) ? 4096 : SLOTS;
  localparam int AW    = (DEPTH <= 2) ? 1 : $clog2(DEPTH);
  localparam logic [16:0] SLOT_LIMIT = 17'(SLOTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_WR   = 4'd4;
  localparam logic [3:0] S_DEN  = 4'd5;
  localparam logic [3:0] S_MAG  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state;
  logic [AW-1:0] clr_addr;
  logic [2:0] mcnt;
  logic [3:0] dcnt;

  logic [dwpli_pkg::CMD_W-1:0]  cmd_r;
  logic [dwpli_pkg::SLOT_W-1:0] slot_r;
  logic signed [dwpli_pkg::X_W-1:0] x_r;

  dwpli_pkg::sums_t mem [DEPTH];
  dwpli_pkg::sums_t mem_q;
  dwpli_pkg::sums_t wdata;
  logic             mem_we;
  logic [AW-1:0]    waddr;

  logic [dwpli_pkg::PROD_W-1:0] prod;
  logic [dwpli_pkg::ACC_W-1:0]  acc0, acc1;
  logic [dwpli_pkg::WIDE_W-2:0] den, mag;
  logic                          neg, zflag;
  logic [dwpli_pkg::QUO_W-1:0]  quo;

  logic [dwpli_pkg::SLOT_W-1:0] out_slot;
  logic [dwpli_pkg::PLI_W-1:0]  out_pli;
  logic                          out_zero;

  // input decode
  logic                          in_fire;
  logic [dwpli_pkg::SLOT_W-1:0] in_slot;
  logic                          in_slot_ok;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign in_slot    = s_axis_tdata[11:0];
  assign in_slot_ok = {5'd0, in_slot} < SLOT_LIMIT;

  // operand magnitudes
  logic [dwpli_pkg::SUM_W-1:0] abs_s;
  logic [dwpli_pkg::X_W-1:0]   abs_x;
  logic                         is_read;
  logic [2:0]                   last_ph;

  assign abs_s   = mem_q.sum[dwpli_pkg::SUM_W-1] ? dwpli_pkg::SUM_W'(-mem_q.sum)
                                                 : dwpli_pkg::SUM_W'(mem_q.sum);
  assign abs_x   = x_r[dwpli_pkg::X_W-1] ? dwpli_pkg::X_W'(-x_r) : dwpli_pkg::X_W'(x_r);
  assign is_read = (cmd_r == dwpli_pkg::CMD_READ);
  assign last_ph = is_read ? 3'd3 : 3'd1;

  // shared multiplier: 34 x 17, one partial product per cycle
  logic [dwpli_pkg::MUL_A_W-1:0] mul_a;
  logic [dwpli_pkg::MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = dwpli_pkg::MUL_A_W'(abs_x);
    mul_b = abs_x[16:0];
    if (is_read) begin
      case (mcnt[1:0])
        2'd0: begin mul_a = abs_s;         mul_b = abs_s[16:0]; end
        2'd1: begin mul_a = abs_s;         mul_b = abs_s[33:17]; end
        2'd2: begin mul_a = mem_q.abs_sum; mul_b = mem_q.abs_sum[16:0]; end
        default: begin mul_a = mem_q.abs_sum; mul_b = mem_q.abs_sum[33:17]; end
      endcase
    end else if (mcnt[0]) begin
      mul_b = dwpli_pkg::MUL_B_W'(abs_x[23:17]);
    end
  end

  logic [2:0] prev_ph;
  logic [dwpli_pkg::ACC_W-1:0] prod_sh;

  assign prev_ph = mcnt - 3'd1;
  assign prod_sh = prev_ph[0] ? {prod, 17'd0} : dwpli_pkg::ACC_W'(prod);

  // shared subtractor; bit WIDE_W-1 is the sign
  logic [dwpli_pkg::WIDE_W-2:0] sub_a, sub_b;
  logic [dwpli_pkg::WIDE_W-1:0] diff;
  logic [dwpli_pkg::WIDE_W-2:0] q_wide;

  assign q_wide = (dwpli_pkg::WIDE_W-1)'(mem_q.sq_sum);

  always_comb begin
    sub_a = {1'b0, acc1};
    sub_b = q_wide;
    case (state)
      S_MAG: begin sub_a = {1'b0, acc0}; sub_b = q_wide; end
      S_CMP: begin sub_a = mag;          sub_b = den; end
      S_DIV: begin sub_a = {mag[dwpli_pkg::WIDE_W-3:0], 1'b0}; sub_b = den; end
      default: begin sub_a = {1'b0, acc1}; sub_b = q_wide; end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};

  // accumulate update with saturation
  logic signed [dwpli_pkg::SUM_W:0]   sum_ext;
  logic [dwpli_pkg::ABS_W:0]          abs_ext;
  logic [dwpli_pkg::SQ_W:0]           sq_ext;
  dwpli_pkg::sums_t                   acc_new;

  always_comb begin
    sum_ext = (dwpli_pkg::SUM_W+1)'($signed(mem_q.sum)) + (dwpli_pkg::SUM_W+1)'(x_r);
    abs_ext = (dwpli_pkg::ABS_W+1)'(mem_q.abs_sum) + (dwpli_pkg::ABS_W+1)'(abs_x);
    sq_ext  = (dwpli_pkg::SQ_W+1)'(mem_q.sq_sum) + (dwpli_pkg::SQ_W+1)'(acc0);
    if (sum_ext > dwpli_pkg::SUM_MAX) begin
      acc_new.sum = dwpli_pkg::SUM_W'(dwpli_pkg::SUM_MAX);
    end else if (sum_ext < dwpli_pkg::SUM_MIN) begin
      acc_new.sum = dwpli_pkg::SUM_W'(dwpli_pkg::SUM_MIN);
    end else begin
      acc_new.sum = dwpli_pkg::SUM_W'(sum_ext);
    end
    acc_new.abs_sum = abs_ext[dwpli_pkg::ABS_W] ? '1 : abs_ext[dwpli_pkg::ABS_W-1:0];
    acc_new.sq_sum  = sq_ext[dwpli_pkg::SQ_W] ? '1 : sq_ext[dwpli_pkg::SQ_W-1:0];
  end

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    waddr  = slot_r[AW-1:0];
    wdata  = acc_new;
    if (state == S_CLR) begin
      mem_we = 1'b1;
      waddr  = clr_addr;
      wdata  = '0;
    end else if (state == S_WR) begin
      mem_we = 1'b1;
    end else if (in_fire && in_slot_ok && s_axis_tuser == dwpli_pkg::CMD_CLEAR) begin
      mem_we = 1'b1;
      waddr  = in_slot[AW-1:0];
      wdata  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q <= mem[in_slot[AW-1:0]];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      mcnt     <= '0;
      dcnt     <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire && in_slot_ok &&
              (s_axis_tuser == dwpli_pkg::CMD_ACC || s_axis_tuser == dwpli_pkg::CMD_READ)) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          mcnt <= mcnt + 3'd1;
          if (mcnt == last_ph + 3'd1) begin
            state <= is_read ? S_DEN : S_WR;
          end
        end
        S_WR: state <= S_IDLE;
        S_DEN: begin
          if (diff[dwpli_pkg::WIDE_W-1] || diff == '0) begin
            state <= S_OUT;
          end else begin
            state <= S_MAG;
          end
        end
        S_MAG: state <= S_CMP;
        S_CMP: begin
          dcnt <= '0;
          state <= diff[dwpli_pkg::WIDE_W-1] ? S_DIV : S_OUT;
        end
        S_DIV: begin
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'(dwpli_pkg::DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= s_axis_tuser;
      slot_r <= in_slot;
      x_r    <= s_axis_tdata[35:12];
    end
    case (state)
      S_RD: begin
        acc0 <= '0;
        acc1 <= '0;
      end
      S_MUL: begin
        if (mcnt <= last_ph) begin
          prod <= mul_a * mul_b;
        end
        if (mcnt != 3'd0) begin
          if (prev_ph[1]) acc1 <= acc1 + prod_sh;
          else            acc0 <= acc0 + prod_sh;
        end
      end
      S_DEN: begin
        den   <= diff[dwpli_pkg::WIDE_W-2:0];
        zflag <= 1'b1;
        neg   <= 1'b0;
        quo   <= '0;
      end
      S_MAG: begin
        zflag <= 1'b0;
        neg   <= diff[dwpli_pkg::WIDE_W-1];
        mag   <= diff[dwpli_pkg::WIDE_W-1] ? (dwpli_pkg::WIDE_W-1)'(-diff)
                                           : diff[dwpli_pkg::WIDE_W-2:0];
      end
      S_CMP: begin
        quo <= diff[dwpli_pkg::WIDE_W-1] ? '0 : dwpli_pkg::ONE_Q16;
      end
      S_DIV: begin
        quo <= {quo[dwpli_pkg::QUO_W-2:0], ~diff[dwpli_pkg::WIDE_W-1]};
        mag <= diff[dwpli_pkg::WIDE_W-1] ? sub_a : diff[dwpli_pkg::WIDE_W-2:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      out_slot <= slot_r;
      out_pli  <= neg ? -{1'b0, quo} : {1'b0, quo};
      out_zero <= zflag;
    end
  end

  assign m_axis_tdata = {2'b00, out_pli, out_slot};
  assign m_axis_tuser = out_zero;

  // checks
  a_div_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> mag < den)
    else $error("divide remainder not below denominator");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_OUT)
    else $error("result shown without a finished read");

  a_zero_den_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[29:12] == '0)
    else $error("zero denominator with nonzero index");

endmodule

>>> tb/debiased_wpli_accumulator_top_test.sv
// Self-checking stream testbench for the debiased wPLI accumulator.
module debiased_wpli_accumulator_top_test;

  localparam logic [dwpli_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [dwpli_pkg::X_W-1:0] X_MIN = 24'sh80_0000;
  localparam logic signed [dwpli_pkg::X_W-1:0] X_MAX = 24'sh7F_FFFF;
  localparam logic [dwpli_pkg::ABS_W-1:0] ABS_LIMIT = {dwpli_pkg::ABS_W{1'b1}};
  localparam logic [dwpli_pkg::SQ_W-1:0] SQ_LIMIT = {dwpli_pkg::SQ_W{1'b1}};
  localparam int RANDOM_ITEMS = 240;

  typedef struct {
    logic [dwpli_pkg::SLOT_W-1:0]       slot;
    logic signed [dwpli_pkg::PLI_W-1:0] pli;
    logic                               zero_den;
  } pli_report_t;

  // Per-slot trial sums and the readouts they should produce.
  class wpli_ledger;
    dwpli_pkg::sums_t tally [4096];
    pli_report_t      pending_reports [$];
    int               failures;

    function new();
      foreach (tally[i]) tally[i] = '0;
      failures = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void take_command(input logic [dwpli_pkg::CMD_W-1:0] cmd,
                               input logic [dwpli_pkg::SLOT_W-1:0] slot,
                               input logic signed [dwpli_pkg::X_W-1:0] x);
      logic signed [dwpli_pkg::X_W:0]     xe;
      logic [dwpli_pkg::X_W-1:0]          ax;
      logic signed [dwpli_pkg::SUM_W+1:0] tsum;
      logic [dwpli_pkg::ABS_W+1:0]        tabs;
      logic [dwpli_pkg::SQ_W+1:0]         tsq;
      logic signed [dwpli_pkg::SUM_W:0]   se;
      logic [dwpli_pkg::SUM_W:0]          mag_s;
      logic [71:0]                        s2, a2, q, den, mag;
      logic [87:0]                        num, quo;
      logic [dwpli_pkg::QUO_W-1:0]        r;
      logic                               neg;
      pli_report_t                        rep;
      dwpli_pkg::sums_t                   cur;
      cur = tally[slot];
      case (cmd)
        dwpli_pkg::CMD_ACC: begin
          xe = x;
          ax = (xe < 0) ? -xe : xe;
          tsum = $signed(cur.sum) + xe;
          if (tsum > dwpli_pkg::SUM_MAX) tsum = dwpli_pkg::SUM_MAX;
          if (tsum < dwpli_pkg::SUM_MIN) tsum = dwpli_pkg::SUM_MIN;
          cur.sum = tsum[dwpli_pkg::SUM_W-1:0];
          tabs = cur.abs_sum + ax;
          if (tabs > ABS_LIMIT) tabs = ABS_LIMIT;
          cur.abs_sum = tabs[dwpli_pkg::ABS_W-1:0];
          tsq = cur.sq_sum + ax * ax;
          if (tsq > SQ_LIMIT) tsq = SQ_LIMIT;
          cur.sq_sum = tsq[dwpli_pkg::SQ_W-1:0];
        end
        dwpli_pkg::CMD_CLEAR: cur = '0;
        dwpli_pkg::CMD_READ: begin
          se = $signed(cur.sum);
          mag_s = (se < 0) ? -se : se;
          s2 = mag_s * mag_s;
          a2 = cur.abs_sum * cur.abs_sum;
          q = cur.sq_sum;
          rep.slot = slot;
          if (a2 <= q) begin
            rep.pli = '0;
            rep.zero_den = 1'b1;
          end else begin
            den = a2 - q;
            neg = s2 < q;
            mag = neg ? q - s2 : s2 - q;
            if (mag >= den) begin
              r = dwpli_pkg::ONE_Q16;
            end else begin
              num = {mag, 16'h0};
              quo = num / den;
              r = quo[dwpli_pkg::QUO_W-1:0];
            end
            rep.pli = neg ? -{1'b0, r} : {1'b0, r};
            rep.zero_den = 1'b0;
          end
          pending_reports.push_back(rep);
        end
        default: ;
      endcase
      tally[slot] = cur;
    endfunction

    function void check_report(input logic [dwpli_pkg::SLOT_W-1:0] slot,
                               input logic [dwpli_pkg::PLI_W-1:0] pli,
                               input logic zero_den);
      pli_report_t want;
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected result: slot %0d pli %0d zero_den %0b",
                       slot, $signed(pli), zero_den));
        return;
      end
      want = pending_reports.pop_front();
      if (slot !== want.slot || pli !== want.pli || zero_den !== want.zero_den)
        flag($sformatf({"result mismatch: expected slot %0d pli %0d zero_den %0b, ",
                        "got slot %0d pli %0d zero_den %0b"},
                       want.slot, want.pli, want.zero_den, slot, $signed(pli), zero_den));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [39:0]                  s_axis_tdata = '0;  // [11:0] slot, [35:12] csd_imag, [39:36] zero
  logic [dwpli_pkg::CMD_W-1:0]  s_axis_tuser = dwpli_pkg::CMD_ACC;  // [1:0] cmd
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;  // [11:0] slot_out, [29:12] phase_lag_index, [31:30] zero
  logic                         m_axis_tuser;  // [0] zero_denominator

  wpli_ledger ledger = new();
  int sender_calm = 0;
  int receiver_calm = 0;
  logic [dwpli_pkg::SLOT_W-1:0] slot_pool [16];

  debiased_wpli_accumulator_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wait before the next item; occasional stretches with no waiting at all.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  function automatic logic signed [dwpli_pkg::X_W-1:0] draw_x(input int mode,
                                                             input bit positive);
    logic signed [dwpli_pkg::X_W-1:0] m;
    case (mode)
      0: return dwpli_pkg::X_W'($urandom);
      1: return dwpli_pkg::X_W'($signed($urandom_range(0, 600)) - 300);
      2: begin
        case ($urandom_range(0, 4))
          0: return X_MIN;
          1: return X_MAX;
          2: return -24'sd1;
          3: return 24'sd1;
          default: return 24'sd0;
        endcase
      end
      default: begin
        m = dwpli_pkg::X_W'($urandom_range(0, 8388607));
        return positive ? m : -m;
      end
    endcase
  endfunction

  task automatic send_item(input logic [dwpli_pkg::CMD_W-1:0] cmd,
                           input logic [dwpli_pkg::SLOT_W-1:0] slot,
                           input logic signed [dwpli_pkg::X_W-1:0] x);
    int gap;
    gap = pick_wait(sender_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, x, slot};
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    ledger.take_command(cmd, slot, x);
  endtask

  // Hold off the input until every outstanding readout has come back.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = pick_wait(receiver_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      ledger.check_report(m_axis_tdata[11:0], m_axis_tdata[29:12], m_axis_tuser);
    end
  end

  initial begin
    int sent, n, mode;
    bit positive;
    logic [dwpli_pkg::SLOT_W-1:0] slot;
    logic [dwpli_pkg::CMD_W-1:0] cmd;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: fresh slot, single trial, same-sign, opposite-sign, clear, unused code
    send_item(dwpli_pkg::CMD_READ, 12'd0, X_MAX);
    send_item(dwpli_pkg::CMD_ACC, 12'd0, X_MAX);
    send_item(dwpli_pkg::CMD_READ, 12'd0, 24'sd0);
    send_item(dwpli_pkg::CMD_ACC, 12'd0, 24'sd5);
    send_item(dwpli_pkg::CMD_READ, 12'd0, X_MIN);
    send_item(CMD_UNUSED, 12'd0, X_MIN);
    send_item(dwpli_pkg::CMD_READ, 12'd0, 24'sd0);
    send_item(dwpli_pkg::CMD_ACC, 12'hFFF, X_MIN);
    send_item(dwpli_pkg::CMD_ACC, 12'hFFF, X_MAX);
    send_item(dwpli_pkg::CMD_READ, 12'hFFF, 24'sd0);
    send_item(dwpli_pkg::CMD_CLEAR, 12'hFFF, X_MAX);
    send_item(dwpli_pkg::CMD_READ, 12'hFFF, 24'sd0);
    send_item(dwpli_pkg::CMD_ACC, 12'h555, 24'sd1);
    send_item(dwpli_pkg::CMD_ACC, 12'h555, -24'sd1);
    send_item(dwpli_pkg::CMD_READ, 12'h555, 24'sd0);
    send_item(dwpli_pkg::CMD_ACC, 12'h555, 24'sd3);
    send_item(dwpli_pkg::CMD_ACC, 12'h555, 24'sd0);
    send_item(dwpli_pkg::CMD_READ, 12'h555, 24'sd0);
    send_item(dwpli_pkg::CMD_ACC, 12'hAAA, -24'sd1);
    send_item(dwpli_pkg::CMD_ACC, 12'hAAA, -24'sd7);
    send_item(dwpli_pkg::CMD_READ, 12'hAAA, 24'sh55_5555);
    send_item(dwpli_pkg::CMD_CLEAR, 12'h0, 24'sh2A_AAAA);
    send_item(dwpli_pkg::CMD_READ, 12'h0, 24'sd0);
    drain_reports();

    // saturation of the signed and square sums on one slot
    for (int i = 0; i < 1030; i++) begin
      send_item(dwpli_pkg::CMD_ACC, 12'h123, X_MIN);
      if (i % 256 == 255) send_item(dwpli_pkg::CMD_READ, 12'h123, 24'sd0);
    end
    send_item(dwpli_pkg::CMD_READ, 12'h123, 24'sd0);
    send_item(dwpli_pkg::CMD_ACC, 12'h123, X_MAX);
    send_item(dwpli_pkg::CMD_READ, 12'h123, 24'sd0);
    drain_reports();

    foreach (slot_pool[i]) slot_pool[i] = dwpli_pkg::SLOT_W'($urandom);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        cmd = dwpli_pkg::CMD_W'($urandom_range(0, 3));
        send_item(cmd, dwpli_pkg::SLOT_W'($urandom), dwpli_pkg::X_W'($urandom));
        sent++;
      end else begin
        slot = ($urandom_range(0, 3) == 0) ? dwpli_pkg::SLOT_W'($urandom)
                                           : slot_pool[$urandom_range(0, 15)];
        if ($urandom_range(0, 4) == 0) begin
          send_item(dwpli_pkg::CMD_CLEAR, slot, dwpli_pkg::X_W'($urandom));
          sent++;
        end
        n = $urandom_range(1, 10);
        mode = $urandom_range(0, 3);
        positive = $urandom_range(0, 1);
        repeat (n) send_item(dwpli_pkg::CMD_ACC, slot, draw_x(mode, positive));
        send_item(dwpli_pkg::CMD_READ, slot, dwpli_pkg::X_W'($urandom));
        sent += n + 1;
      end
      if ($urandom_range(0, 39) == 0) drain_reports();
    end

    s_axis_tvalid <= 1'b0;
    while (ledger.pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.failures == 0 && ledger.pending_reports.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #30000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/dwpli_pkg.sv
hw/rtl/debiased_wpli_accumulator_top.sv
tb/debiased_wpli_accumulator_top_test.sv
